// File: sv/neighbor_mean_grid_step_macros.svh
// Assertion macros for the neighbor mean grid step block.
// Taken in by the top level; depends on nothing else.
`ifndef NEIGHBOR_MEAN_GRID_STEP_MACROS_SVH
`define NEIGHBOR_MEAN_GRID_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NMGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nmgs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NMGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nmgs assertion failed");

`endif

// File: sv/nmgs_pkg.sv
// Package for the neighbor mean grid step block: default sizes and shared types.
// Used by the scan, the window and the top level.
package nmgs_pkg;

	localparam int MAX_SIDE_DEF = 64;
	localparam int CELL_BITS_DEF = 4;
	localparam int GRID_SIDE_RESET = 42;
	localparam int MIN_SIDE = 3;
	localparam int NEIGHBOR_SHIFT = 3;
	localparam int WINDOW_CELLS = 6;

	typedef struct packed {
		logic emit;
		logic last;
	} scan_ctl_t;

endpackage

// File: sv/nmgs_ifs.sv
// Valid/ready channel interfaces of the neighbor mean grid step block.
// Widths come from their own parameters; no other dependencies.
interface nmgs_in_if #(parameter int CELL_BITS = 4);
	logic valid;
	logic ready;
	logic [CELL_BITS-1:0] cell_value;
	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

interface nmgs_out_if #(parameter int CELL_BITS = 4, parameter int POS_BITS = 6);
	logic valid;
	logic ready;
	logic [CELL_BITS-1:0] new_value;
	logic [POS_BITS-1:0] cell_row;
	logic [POS_BITS-1:0] cell_col;
	logic last_of_grid;
	modport source (output valid, output new_value, output cell_row, output cell_col,
		output last_of_grid, input ready);
	modport sink (input valid, input new_value, input cell_row, input cell_col,
		input last_of_grid, output ready);
endinterface

interface nmgs_cfg_if #(parameter int SIDE_BITS = 7);
	logic valid;
	logic ready;
	logic [SIDE_BITS-1:0] grid_side;
	modport source (output valid, output grid_side, input ready);
	modport sink (input valid, input grid_side, output ready);
endinterface

// File: sv/nmgs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module nmgs_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/nmgs_scan.sv
// Grid side register and raster position counters of the neighbor mean grid step.
// Depends on nmgs_pkg and the configuration interface.
module nmgs_scan
	import nmgs_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nmgs_cfg_if.sink                      cfg,
	input  logic                          accept,
	output logic [$clog2(MAX_SIDE)-1:0]   row,
	output logic [$clog2(MAX_SIDE)-1:0]   col,
	output logic [$clog2(MAX_SIDE)-1:0]   out_row,
	output logic [$clog2(MAX_SIDE)-1:0]   out_col,
	output scan_ctl_t                     ctl
);

	localparam int POS_BITS = $clog2(MAX_SIDE);
	localparam int SIDE_BITS = $clog2(MAX_SIDE + 1);
	localparam int RESET_SIDE = (GRID_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : GRID_SIDE_RESET;

	logic [POS_BITS-1:0]  side_m1_q;
	logic [POS_BITS-1:0]  row_q;
	logic [POS_BITS-1:0]  col_q;
	logic [SIDE_BITS-1:0] side_new;
	logic                 cfg_write;
	logic                 row_end;
	logic                 col_end;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	always_comb begin
		if (cfg.grid_side < SIDE_BITS'(MIN_SIDE)) begin
			side_new = SIDE_BITS'(MIN_SIDE);
		end else if (cfg.grid_side > SIDE_BITS'(MAX_SIDE)) begin
			side_new = SIDE_BITS'(MAX_SIDE);
		end else begin
			side_new = cfg.grid_side;
		end
	end

	assign row_end = (row_q == side_m1_q);
	assign col_end = (col_q == side_m1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_m1_q <= POS_BITS'(RESET_SIDE - 1);
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_write) begin
			side_m1_q <= POS_BITS'(side_new - SIDE_BITS'(1));
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + POS_BITS'(1);
			end else begin
				col_q <= col_q + POS_BITS'(1);
			end
		end
	end

	assign row = row_q;
	assign col = col_q;
	assign out_row = row_q - POS_BITS'(1);
	assign out_col = col_q - POS_BITS'(1);
	assign ctl.emit = (row_q >= POS_BITS'(2)) && (col_q >= POS_BITS'(2));
	assign ctl.last = row_end && col_end;

endmodule

// File: sv/nmgs_window.sv
// Row stores, 3x3 window and result register of the neighbor mean grid step.
// Depends on nmgs_pkg, nmgs_ram and the cell channel interfaces.
module nmgs_window
	import nmgs_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int CELL_BITS = CELL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	nmgs_in_if.sink                     cell_in,
	nmgs_out_if.source                  cell_out,
	input  logic [$clog2(MAX_SIDE)-1:0] col,
	input  logic [$clog2(MAX_SIDE)-1:0] out_row,
	input  logic [$clog2(MAX_SIDE)-1:0] out_col,
	input  scan_ctl_t                   ctl,
	output logic                        accept
);

	localparam int POS_BITS = $clog2(MAX_SIDE);
	localparam int SUM_BITS = CELL_BITS + NEIGHBOR_SHIFT;

	logic                 valid_s1;
	scan_ctl_t            ctl_s1;
	logic [POS_BITS-1:0]  col_s1;
	logic [POS_BITS-1:0]  row_out_s1;
	logic [POS_BITS-1:0]  col_out_s1;
	logic [CELL_BITS-1:0] cell_s1;
	logic [CELL_BITS-1:0] win_q [WINDOW_CELLS];
	logic [CELL_BITS-1:0] top;
	logic [CELL_BITS-1:0] mid;
	logic [SUM_BITS-1:0]  sum;
	logic                 take;
	logic                 adv_s1;
	logic                 out_valid_q;

	// Stage 1 moves on unless it holds a result and the result register is stuck.
	assign adv_s1 = valid_s1 && (!ctl_s1.emit || !out_valid_q || cell_out.ready);
	assign take = !valid_s1 || adv_s1;
	assign accept = cell_in.valid && take;
	assign cell_in.ready = take;

	nmgs_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_SIDE)) u_upper_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (mid),
		.re    (accept),
		.raddr (col),
		.rdata (top)
	);

	nmgs_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_SIDE)) u_middle_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (cell_s1),
		.re    (accept),
		.raddr (col),
		.rdata (mid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
			col_s1 <= col;
			row_out_s1 <= out_row;
			col_out_s1 <= out_col;
			cell_s1 <= cell_in.cell_value;
		end
	end

	// The window holds the two columns left of the incoming one; the center is left out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_CELLS; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= cell_s1;
		end
	end

	assign sum = SUM_BITS'(win_q[0]) + SUM_BITS'(win_q[1]) + SUM_BITS'(win_q[2])
		+ SUM_BITS'(win_q[3]) + SUM_BITS'(win_q[5])
		+ SUM_BITS'(top) + SUM_BITS'(mid) + SUM_BITS'(cell_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (cell_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctl_s1.emit) begin
			cell_out.new_value <= sum[SUM_BITS-1 -: CELL_BITS];
			cell_out.cell_row <= row_out_s1;
			cell_out.cell_col <= col_out_s1;
			cell_out.last_of_grid <= ctl_s1.last;
		end
	end

	assign cell_out.valid = out_valid_q;

endmodule

// File: sv/neighbor_mean_grid_step.sv
// Top level of the neighbor mean grid step block: one generation of a 3x3 neighbor mean.
// Depends on nmgs_pkg, the channel interfaces, nmgs_scan, nmgs_window and the macros header.
//
// Usage: cells of the current grid enter on cell_in in raster order, one request per
// cell. For every interior cell a request leaves on cell_out with the new value (sum of
// the eight neighbors divided by eight, truncated), its row and column, and a flag on
// the last interior cell of the grid. Border cells produce nothing. A result belongs to
// the cell one row and one column behind the input that completes its window.
// The cfg channel writes the grid side (clamped to 3..MAX_SIDE) and restarts the grid at
// row 0, column 0; it is always ready. It must be written only while the block is idle;
// the block itself does not enforce this. Throughput is one cell per cycle while cell_out
// takes results. A cell that completes a result is registered in stage 1 together with
// the row store read, and the window sum then goes straight into the result register.
// Reset clears the position counters, the window and both pipeline valid bits and sets
// the side to 42 (MAX_SIDE if smaller); the row stores are not cleared, since rows 0 and 1
// never emit. When cell_out stalls, the result register holds, as does stage 1 once it holds
// a result; cell_in stays ready until a result waits in stage 1 behind a full result register.
`include "neighbor_mean_grid_step_macros.svh"

module neighbor_mean_grid_step
	import nmgs_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int CELL_BITS = CELL_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	nmgs_cfg_if.sink     cfg,
	nmgs_in_if.sink      cell_in,
	nmgs_out_if.source   cell_out
);

	localparam int POS_BITS = $clog2(MAX_SIDE);

	logic [POS_BITS-1:0] row;
	logic [POS_BITS-1:0] col;
	logic [POS_BITS-1:0] out_row;
	logic [POS_BITS-1:0] out_col;
	scan_ctl_t           ctl;
	logic                accept;

	nmgs_scan #(.MAX_SIDE(MAX_SIDE)) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.row     (row),
		.col     (col),
		.out_row (out_row),
		.out_col (out_col),
		.ctl     (ctl)
	);

	nmgs_window #(.MAX_SIDE(MAX_SIDE), .CELL_BITS(CELL_BITS)) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.cell_in  (cell_in),
		.cell_out (cell_out),
		.col      (col),
		.out_row  (out_row),
		.out_col  (out_col),
		.ctl      (ctl),
		.accept   (accept)
	);

	`NMGS_ASSERT_NOW(a_last_on_diagonal, clk, arst_n,
		cell_out.valid && cell_out.last_of_grid, cell_out.cell_row == cell_out.cell_col)
	`NMGS_ASSERT_NOW(a_interior_only, clk, arst_n,
		cell_out.valid, (cell_out.cell_row != '0) && (cell_out.cell_col != '0))
	`NMGS_ASSERT_NEXT(a_cfg_restarts, clk, arst_n,
		cfg.valid && cfg.ready, (row == '0) && (col == '0))
	`NMGS_ASSERT_NOW(a_stall_needs_result, clk, arst_n,
		!cell_in.ready, cell_out.valid && !cell_out.ready)

endmodule
